@@ hdl/sts_pkg.sv @@
// Shared types and constants for the sorted timestamp window.
// No dependencies; every other file of the block but sts_stream_if imports this package.
package sts_pkg;

    localparam int STS_DEPTH = 64;
    localparam int STS_WORD  = 64;

    typedef logic [STS_WORD-1:0] t_word;

    typedef enum logic {
        ACT_RECORD   = 1'b0,
        ACT_SNAPSHOT = 1'b1
    } t_action;

    typedef struct packed {
        logic  action;
        t_word frame_sequence_in;
        t_word present_time;
    } t_in_item;

    typedef struct packed {
        logic  accepted;
        t_word latest_time;
        t_word latest_gap;
        t_word gap_sequence;
        t_word gap_length;
        logic  gap_valid;
        logic  last;
    } t_out_item;

    // One store entry: sequence number and timestamp side by side.
    typedef struct packed {
        t_word seq;
        t_word ts;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_PUT,
        ST_TL1,
        ST_TL2,
        ST_TL3,
        ST_REP,
        ST_SRD,
        ST_SCAP,
        ST_SEMIT
    } t_state;

endpackage

@@ hdl/sts_stream_if.sv @@
// Valid/ready stream interface carrying one payload of type T.
// Depends on nothing; the payload type is supplied by the user.
interface sts_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sts_store.sv @@
// Entry memory of the window: one write port, one read port, registered read data.
// Depends on sts_pkg.
module sts_store import sts_pkg::*; #(
    parameter  int STORE_DEPTH = STS_DEPTH,
    localparam int IW          = $clog2(STORE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [IW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [STORE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sts_ctrl.sv @@
// Sequencer of the window: search, shift, insert, newest-pair readout and snapshot walk.
// Depends on sts_pkg and sts_stream_if; drives the ports of sts_store.
module sts_ctrl import sts_pkg::*; #(
    parameter  int STORE_DEPTH = STS_DEPTH,
    localparam int IW          = $clog2(STORE_DEPTH),
    localparam int CW          = $clog2(STORE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sts_stream_if.sink    i_in,
    sts_stream_if.source  o_res,
    output logic          o_we,
    output logic [IW-1:0] o_waddr,
    output t_entry        o_wdata,
    output logic [IW-1:0] o_raddr,
    input  t_entry        i_rdata
);

    localparam logic [CW-1:0] FULL_C = CW'(STORE_DEPTH);
    localparam logic [IW-1:0] TOP_C  = IW'(STORE_DEPTH - 1);

    t_state    r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic      r_pend, n_pend;
    logic      r_more, n_more;
    logic      r_out_valid, n_out_valid;

    t_word     r_seq, n_seq;
    t_word     r_ts, n_ts;
    logic      r_evict, n_evict;
    logic      r_snap, n_snap;
    logic      r_acc, n_acc;
    logic [IW-1:0] r_ptr, n_ptr;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_pos, n_pos;
    t_word     r_new, n_new;
    t_word     r_prev, n_prev;
    t_entry    r_cur, n_cur;
    t_out_item r_out, n_out;

    logic in_acc;
    logic can_load;
    logic d_eq;
    logic d_lt;
    logic idx_at_fill;
    logic ptr_at_fill;
    logic in_bad;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign in_acc      = i_in.valid && (r_state == ST_IDLE);
    assign can_load    = !r_out_valid || o_res.ready;
    assign d_eq        = (i_rdata.ts == r_ts);
    assign d_lt        = (i_rdata.ts < r_ts);
    assign idx_at_fill = ((CW'(r_idx) + CW'(1)) == r_fill);
    assign ptr_at_fill = ((CW'(r_ptr) + CW'(1)) == r_fill);
    assign in_bad      = (i_in.data.frame_sequence_in == '0) || (i_in.data.present_time == '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.action == ACT_SNAPSHOT) begin
                        n_state = (r_fill < CW'(2)) ? ST_REP : ST_SRD;
                    end else if (in_bad) begin
                        n_state = ST_TL1;
                    end else if (r_fill == '0) begin
                        n_state = ST_PUT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_pend) begin
                    if (r_evict) begin
                        // Ascending search; a stale or duplicate timestamp is dropped.
                        if ((r_idx == '0 && !d_lt) || d_eq) begin
                            n_state = ST_TL1;
                        end else if (!d_lt) begin
                            n_state = (r_idx == IW'(1)) ? ST_PUT : ST_MOVE;
                        end else if (r_idx == TOP_C) begin
                            n_state = ST_MOVE;
                        end
                    end else begin
                        if (d_eq) begin
                            n_state = ST_TL1;
                        end else if (d_lt) begin
                            n_state = idx_at_fill ? ST_PUT : ST_MOVE;
                        end else if (r_idx == '0) begin
                            n_state = ST_MOVE;
                        end
                    end
                end
            end
            ST_MOVE: begin
                if (!r_more && r_pend) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT:  n_state = ST_TL1;
            ST_TL1:  n_state = ST_TL2;
            ST_TL2:  n_state = ST_TL3;
            ST_TL3:  n_state = ST_REP;
            ST_REP: begin
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SRD:  n_state = ST_SCAP;
            ST_SCAP: n_state = (r_ptr == '0) ? ST_SRD : ST_SEMIT;
            ST_SEMIT: begin
                if (can_load) begin
                    n_state = ptr_at_fill ? ST_IDLE : ST_SRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory ports and result register.
    always_comb begin
        n_fill      = r_fill;
        n_pend      = r_pend;
        n_more      = r_more;
        n_out_valid = r_out_valid;
        n_seq       = r_seq;
        n_ts        = r_ts;
        n_evict     = r_evict;
        n_snap      = r_snap;
        n_acc       = r_acc;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_new       = r_new;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_out       = r_out;
        o_we        = 1'b0;
        o_waddr     = r_pos;
        o_wdata     = i_rdata;
        o_raddr     = r_ptr;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_seq   = i_in.data.frame_sequence_in;
                    n_ts    = i_in.data.present_time;
                    n_snap  = i_in.data.action;
                    n_acc   = 1'b0;
                    n_evict = (r_fill == FULL_C);
                    n_pend  = 1'b0;
                    n_more  = 1'b1;
                    n_pos   = '0;
                    if (i_in.data.action == ACT_SNAPSHOT || r_fill == FULL_C) begin
                        n_ptr = '0;
                    end else begin
                        n_ptr = IW'(r_fill - CW'(1));
                    end
                end
            end
            ST_SCAN: begin
                // Reads issue one per cycle; each read is judged in the next cycle.
                if (r_more) begin
                    n_pend = 1'b1;
                    n_idx  = r_ptr;
                    n_ptr  = r_evict ? r_ptr + IW'(1) : r_ptr - IW'(1);
                    n_more = r_evict ? (r_ptr != TOP_C) : (r_ptr != '0);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_evict) begin
                        if (!((r_idx == '0 && !d_lt) || d_eq)) begin
                            if (!d_lt || r_idx == TOP_C) begin
                                n_pos  = d_lt ? TOP_C : r_idx - IW'(1);
                                n_ptr  = IW'(1);
                                n_more = 1'b1;
                                n_pend = 1'b0;
                            end
                        end
                    end else if (!d_eq) begin
                        if (d_lt || r_idx == '0) begin
                            n_pos  = d_lt ? r_idx + IW'(1) : '0;
                            n_ptr  = IW'(r_fill - CW'(1));
                            n_more = 1'b1;
                            n_pend = 1'b0;
                        end
                    end
                end
            end
            ST_MOVE: begin
                // Full store shifts toward the oldest slot, otherwise toward the newest.
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_evict ? r_idx - IW'(1) : r_idx + IW'(1);
                    o_wdata = i_rdata;
                end
                if (r_more) begin
                    n_pend = 1'b1;
                    n_idx  = r_ptr;
                    n_ptr  = r_evict ? r_ptr + IW'(1) : r_ptr - IW'(1);
                    n_more = (r_ptr != r_pos);
                end else begin
                    n_pend = 1'b0;
                end
            end
            ST_PUT: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = '{seq: r_seq, ts: r_ts};
                n_acc   = 1'b1;
                if (!r_evict) begin
                    n_fill = r_fill + CW'(1);
                end
            end
            ST_TL1: begin
                o_raddr = IW'(r_fill - CW'(1));
            end
            ST_TL2: begin
                o_raddr = IW'(r_fill - CW'(2));
                n_new   = i_rdata.ts;
            end
            ST_TL3: begin
                n_prev = i_rdata.ts;
            end
            ST_REP: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    if (!r_snap) begin
                        n_out.accepted    = r_acc;
                        n_out.latest_time = (r_fill != '0) ? r_new : '0;
                        n_out.latest_gap  = (r_fill >= CW'(2)) ? r_new - r_prev : '0;
                    end
                end
            end
            ST_SRD: begin
                o_raddr = r_ptr;
            end
            ST_SCAP: begin
                if (r_ptr == '0) begin
                    n_prev = i_rdata.ts;
                    n_ptr  = IW'(1);
                end else begin
                    n_cur = i_rdata;
                end
            end
            ST_SEMIT: begin
                if (can_load) begin
                    n_out_valid        = 1'b1;
                    n_out              = '0;
                    n_out.gap_sequence = r_cur.seq;
                    n_out.gap_length   = r_cur.ts - r_prev;
                    n_out.gap_valid    = 1'b1;
                    n_out.last         = ptr_at_fill;
                    n_prev             = r_cur.ts;
                    n_ptr              = r_ptr + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq   <= n_seq;
        r_ts    <= n_ts;
        r_evict <= n_evict;
        r_snap  <= n_snap;
        r_acc   <= n_acc;
        r_ptr   <= n_ptr;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_new   <= n_new;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_out   <= n_out;
    end

endmodule

@@ hdl/sorted_timestamp_window.sv @@
// Sorted timestamp window: a bounded history of sequence/timestamp pairs.
// i_in takes requests: action 0 records a pair, action 1 asks for a snapshot.
// o_res returns results; a record gives one result, a snapshot one result per
// neighboring pair (oldest first) with last set on the final one, or a single
// result with gap_valid low when fewer than two entries are held.
// Entries live in one memory with a registered read, sorted oldest first.
// Record: a search over the entries newer than the new timestamp (or, when
// the store is full, older ones), then a shift of the same entries, one
// entry per cycle; a request with a zero field skips both. In-order timestamps
// take the short path only until the store fills; after that every insert
// walks and shifts the whole store.
// Snapshot: the oldest timestamp is read first, then each result passes through
// a read, a capture and an emit state, set by the single read port.
// One request is handled at a time; i_in.ready is high only when idle.
// A finished result waits in the output register while the next request is
// taken; when the receiver stalls, the block holds before writing a new result.
// Reset clears the fill count and the control state at once; the memory keeps
// whatever it holds, since entries at or above the fill count never reach a result.
module sorted_timestamp_window import sts_pkg::*; #(
    parameter int STORE_DEPTH = STS_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sts_stream_if.sink   i_in,
    sts_stream_if.source o_res
);

    localparam int IW = $clog2(STORE_DEPTH);

    logic          we;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;
    t_entry        wdata;
    t_entry        rdata;

    sts_ctrl #(.STORE_DEPTH(STORE_DEPTH)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_res   (o_res),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    sts_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

@@ hdl/sts_chk.sv @@
// Port-level checks of the sorted timestamp window, bound to its top level.
// Depends on sts_pkg and sorted_timestamp_window.
module sts_chk import sts_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_res_valid,
    input logic      i_res_ready,
    input t_out_item i_res_data
);

    // A stalled result stays offered and unchanged.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result dropped or changed while stalled");

    // Ready drops once a request is taken, so requests are never taken back to back.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken back to back");

    // Only snapshot gaps can be followed by more results of the same request.
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.last |-> i_res_data.gap_valid && !i_res_data.accepted)
        else $error("non-final result is not a snapshot gap");

    // An inserted pair leaves a nonzero newest timestamp in a lone record result.
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.accepted |->
            i_res_data.latest_time != '0 && i_res_data.last && !i_res_data.gap_valid)
        else $error("accepted record with empty store or snapshot fields");

endmodule

bind sorted_timestamp_window sts_chk u_sts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

@@ tb/tb_top.sv @@
// Self-checking bench for sorted_timestamp_window: directed and random record and
// snapshot requests, checked against an in-bench model of the sorted history.
// Depends on hdl/sts_pkg.sv, hdl/sts_stream_if.sv and hdl/sorted_timestamp_window.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int REQUEST_TOTAL = 230;
    localparam int PRINT_CAP     = 40;

    logic i_clk;
    logic i_rst_n;

    sts_stream_if #(.T(t_in_item))  req_if ();
    sts_stream_if #(.T(t_out_item)) res_if ();

    sorted_timestamp_window dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_res   (res_if)
    );

    // Model of the history window, kept oldest first.
    t_word     hist_time [STS_DEPTH];
    t_word     hist_seq  [STS_DEPTH];
    int        hist_fill;
    t_out_item gap_and_record_q[$];

    t_in_item  pending_req_q[$];
    t_word     issued_ts[$];

    int  accepted_reqs;
    int  quiet_after;
    bit  quiet;
    int  results_seen;
    int  mismatches;
    int  records_seen;
    int  records_taken;
    int  evictions;
    int  snapshots_seen;
    int  peak_fill;

    int  req_gap;
    int  req_free;
    int  res_gap;
    int  res_free;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // Returns 1 when the pair goes into the window.
    function automatic bit insert_pair(t_word seq, t_word ts);
        int pos;
        if (seq == '0 || ts == '0)
            return 1'b0;
        pos = 0;
        while (pos < hist_fill && hist_time[pos] < ts)
            pos++;
        if (pos < hist_fill && hist_time[pos] == ts)
            return 1'b0;
        if (hist_fill == STS_DEPTH) begin
            // A full window only takes a pair newer than its oldest entry.
            if (ts <= hist_time[0])
                return 1'b0;
            for (int i = 1; i < hist_fill; i++) begin
                hist_time[i-1] = hist_time[i];
                hist_seq[i-1]  = hist_seq[i];
            end
            hist_fill--;
            pos--;
            evictions++;
        end
        for (int i = hist_fill; i > pos; i--) begin
            hist_time[i] = hist_time[i-1];
            hist_seq[i]  = hist_seq[i-1];
        end
        hist_time[pos] = ts;
        hist_seq[pos]  = seq;
        hist_fill++;
        if (hist_fill > peak_fill)
            peak_fill = hist_fill;
        return 1'b1;
    endfunction

    function automatic void predict_request(t_in_item req);
        t_out_item r;
        r = '0;
        if (req.action == ACT_RECORD) begin
            records_seen++;
            r.accepted = insert_pair(req.frame_sequence_in, req.present_time);
            if (r.accepted)
                records_taken++;
            if (hist_fill > 0)
                r.latest_time = hist_time[hist_fill-1];
            if (hist_fill > 1)
                r.latest_gap = hist_time[hist_fill-1] - hist_time[hist_fill-2];
            r.last = 1'b1;
            gap_and_record_q.push_back(r);
        end else begin
            snapshots_seen++;
            if (hist_fill < 2) begin
                r.last = 1'b1;
                gap_and_record_q.push_back(r);
            end else begin
                for (int i = 1; i < hist_fill; i++) begin
                    r = '0;
                    r.gap_sequence = hist_seq[i];
                    r.gap_length   = hist_time[i] - hist_time[i-1];
                    r.gap_valid    = 1'b1;
                    r.last         = (i == hist_fill - 1);
                    gap_and_record_q.push_back(r);
                end
            end
        end
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t ns] MISMATCH: %s", $time, msg);
    endtask

    task automatic compare_field(string name, t_word got, t_word want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got %h, expected %h",
                                      results_seen, name, got, want));
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        results_seen++;
        if (gap_and_record_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no request pending",
                                      results_seen));
            return;
        end
        want = gap_and_record_q.pop_front();
        compare_field("accepted",     t_word'(got.accepted),  t_word'(want.accepted));
        compare_field("latest_time",  got.latest_time,        want.latest_time);
        compare_field("latest_gap",   got.latest_gap,         want.latest_gap);
        compare_field("gap_sequence", got.gap_sequence,       want.gap_sequence);
        compare_field("gap_length",   got.gap_length,         want.gap_length);
        compare_field("gap_valid",    t_word'(got.gap_valid), t_word'(want.gap_valid));
        compare_field("last",         t_word'(got.last),      t_word'(want.last));
    endtask

    function automatic void queue_record(t_word seq, t_word ts);
        t_in_item req;
        req.action            = ACT_RECORD;
        req.frame_sequence_in = seq;
        req.present_time      = ts;
        pending_req_q.push_back(req);
        if (ts != '0)
            issued_ts.push_back(ts);
    endfunction

    // The sequence and time fields are don't-care on a snapshot; fill them anyway.
    function automatic void queue_snapshot();
        t_in_item req;
        req.action            = ACT_SNAPSHOT;
        req.frame_sequence_in = rand_word();
        req.present_time      = rand_word();
        pending_req_q.push_back(req);
    endfunction

    // Request driver: holds a request until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_request(req_if.data);
                accepted_reqs++;
                if (accepted_reqs >= quiet_after)
                    quiet <= 1'b1;
            end
            if (!(req_if.valid && !req_if.ready)) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_req_q.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (!quiet && req_free == 0 && $urandom_range(0, 5) == 0) begin
                    req_gap = $urandom_range(0, 5);
                    if ($urandom_range(0, 3) == 0)
                        req_free = $urandom_range(20, 60);
                    req_if.valid <= 1'b0;
                end else begin
                    if (req_free > 0)
                        req_free--;
                    req_if.data  <= pending_req_q.pop_front();
                    req_if.valid <= 1'b1;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready)
                check_result(res_if.data);
            if (res_gap > 0) begin
                res_gap--;
                res_if.ready <= 1'b0;
            end else if (!quiet && res_free == 0 && $urandom_range(0, 5) == 0) begin
                res_gap = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0)
                    res_free = $urandom_range(20, 60);
                res_if.ready <= 1'b0;
            end else begin
                if (res_free > 0)
                    res_free--;
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d results still pending", gap_and_record_q.size());
        $display("sorted_timestamp_window regression: fail");
        $finish;
    end

    initial begin
        t_word now_ts;
        t_word delta;
        t_word seq;
        t_word ts;
        int    kind;
        int    random_count;

        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        quiet        = 1'b0;
        quiet_after  = REQUEST_TOTAL * 4 / 5;

        // Directed opening: empty and single-entry snapshots, invalid pairs,
        // duplicates, inserts in front and in the middle, and extreme values.
        queue_snapshot();
        queue_record('0, 64'd100);
        queue_record(64'd5, '0);
        queue_record('0, '0);
        queue_record(64'd1, 64'd1000);
        queue_snapshot();
        queue_record('1, 64'd2000);
        queue_snapshot();
        queue_record(64'd3, 64'd1000);
        queue_record(64'd4, 64'd1500);
        queue_record(64'd5, 64'd500);
        queue_record(64'd6, '1);
        queue_record(64'd7, 64'h8000_0000_0000_0000);
        queue_record(64'd8, '1);
        queue_record(64'd9, 64'd1);
        queue_snapshot();

        // Random part: mostly an advancing clock so the window fills and starts
        // evicting, mixed with late, stale, duplicate, invalid and wide stamps.
        now_ts       = 64'd3000;
        random_count = REQUEST_TOTAL - pending_req_q.size();
        for (int n = 0; n < random_count; n++) begin
            kind = $urandom_range(0, 99);
            seq  = rand_word();
            if (seq == '0)
                seq = 64'd1;
            if (kind < 10) begin
                queue_snapshot();
            end else begin
                if (kind < 60) begin
                    now_ts += t_word'($urandom_range(1, 1000));
                    ts = now_ts;
                end else if (kind < 72) begin
                    delta = t_word'($urandom_range(0, 20000));
                    ts = (now_ts > delta) ? now_ts - delta : 64'd1;
                end else if (kind < 82) begin
                    ts = issued_ts[$urandom_range(0, issued_ts.size() - 1)];
                end else if (kind < 88) begin
                    ts = t_word'($urandom_range(1, 3000));
                end else if (kind < 94) begin
                    ts = now_ts + 64'd1;
                    case ($urandom_range(0, 2))
                        0: seq = '0;
                        1: ts  = '0;
                        default: begin
                            seq = '0;
                            ts  = '0;
                        end
                    endcase
                end else if (kind < 97) begin
                    ts = rand_word();
                    if (ts == '0)
                        ts = 64'd7;
                end else begin
                    now_ts += {$urandom_range(0, 255), $urandom};
                    ts = now_ts;
                end
                queue_record(seq, ts);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (accepted_reqs < REQUEST_TOTAL || gap_and_record_q.size() != 0);
        // Let any stray result surface before the verdict.
        repeat (300) @(negedge i_clk);

        $display("Covered %0d requests: %0d records (%0d taken, %0d evictions), %0d snapshots.",
                 accepted_reqs, records_seen, records_taken, evictions, snapshots_seen);
        $display("Checked %0d results; the window peaked at %0d of %0d entries.",
                 results_seen, peak_fill, STS_DEPTH);
        if (mismatches == 0 && gap_and_record_q.size() == 0) begin
            $display("sorted_timestamp_window regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("sorted_timestamp_window regression: fail");
        end
        $finish;
    end

endmodule
